@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rmslm_pkg.sv @@
// Package: widths, constants, controller states and command/status types of the level meter.
`default_nettype none

package rmslm_pkg;

   localparam int unsigned MAX_WINDOW = 128;

   localparam int RAW_W    = 32;
   localparam int SAMPLE_W = 16;
   localparam int SQUARE_W = 2 * SAMPLE_W;
   localparam int SUM_W    = 38;
   localparam int COUNT_W  = 8;
   localparam int RMS_W    = 16;
   localparam int LEVEL_W  = 7;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int SQREM_W  = ROOT_W + 2;
   localparam int ITER_W   = 6;

   localparam int DIV_STEPS  = SUM_W;
   localparam int SQRT_STEPS = SUM_W / 2;

   localparam logic [COUNT_W-1:0] WINDOW_RESET = 8'd100;

   localparam int LEVEL_SCALE       = 100;
   localparam int LEVEL_MAX         = 100;
   localparam int FULL_SCALE_SHIFT  = 15;
   localparam int LEVEL_PROD_W      = ROOT_W + LEVEL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic accum;
      logic div_step;
      logic sqrt_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic div_last;
      logic sqrt_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ sv/rmslm_req_if.sv @@
// Interface: input channel carrying one raw receiver word per transfer.
`default_nettype none

interface rmslm_req_if import rmslm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_word;
   logic                    read_failed;

   modport source (output valid, output raw_word, output read_failed, input ready);
   modport sink   (input valid, input raw_word, input read_failed, output ready);
endinterface

`default_nettype wire

@@ sv/rmslm_rsp_if.sv @@
// Interface: result channel carrying one level measurement per transfer.
`default_nettype none

interface rmslm_rsp_if import rmslm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RMS_W-1:0]   rms_value;
   logic [LEVEL_W-1:0] level;
   logic [COUNT_W-1:0] sample_count;

   modport source (output valid, output rms_value, output level, output sample_count,
                   input ready);
   modport sink   (input valid, input rms_value, input level, input sample_count,
                   output ready);
endinterface

`default_nettype wire

@@ sv/rmslm_ctrl.sv @@
// Controller state machine: sequences capture, accumulate, divide, square root and result load.
`default_nettype none

module rmslm_ctrl import rmslm_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            state_in = status.close ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_last) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/rmslm_datapath.sv @@
// Datapath: window accumulator, restoring divider, digit square root and output register.
`default_nettype none

module rmslm_datapath import rmslm_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire        [COUNT_W-1:0]   csr_wr_data,
   input  cmd_type                    cmd,
   output status_type                 status,
   input  wire signed [RAW_W-1:0]     raw_word,
   input  wire                        read_failed,
   input  wire                        rsp_ready,
   output logic                       rsp_valid,
   output logic       [RMS_W-1:0]     rms_value,
   output logic       [LEVEL_W-1:0]   level,
   output logic       [COUNT_W-1:0]   sample_count
);

   // Window length register
   logic [COUNT_W-1:0]  window_ff;
   logic [COUNT_W-1:0]  limit;

   // Captured item
   logic [SAMPLE_W-1:0] mag_ff;
   logic                fail_ff;
   logic [SAMPLE_W-1:0] hi_word;
   logic [SAMPLE_W-1:0] mag_in;

   // Accumulator
   logic [SUM_W-1:0]    sum_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [SQUARE_W-1:0] square;
   logic [SUM_W-1:0]    sum_new;
   logic [COUNT_W-1:0]  count_new;
   logic                close;

   // Divider / square root
   logic [SUM_W-1:0]    work_ff;
   logic [COUNT_W-1:0]  div_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [ITER_W-1:0]   iter_ff;
   logic [COUNT_W:0]    div_trial;
   logic                div_ge;
   logic [COUNT_W:0]    div_diff;
   logic [SQREM_W-1:0]  sqrem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [SQREM_W+1:0]  sq_shift;
   logic [SQREM_W+1:0]  sq_trial;
   logic                sq_ge;
   logic [SQREM_W+1:0]  sq_diff;
   logic                div_last;
   logic                sqrt_last;

   // Result
   logic [COUNT_W-1:0]      count_out_ff;
   logic                    rsp_valid_ff;
   logic [RMS_W-1:0]        rms_ff;
   logic [LEVEL_W-1:0]      level_ff;
   logic [COUNT_W-1:0]      count_rsp_ff;
   logic [LEVEL_PROD_W-1:0] level_prod;
   logic [LEVEL_PROD_W-FULL_SCALE_SHIFT-1:0] level_scaled;
   logic [LEVEL_W-1:0]      level_in;
   logic                    out_free;

   // Effective window length: zero acts as one, saturate at the maximum
   always_comb begin
      limit = window_ff;
      if (window_ff == '0) limit = COUNT_W'(1);
      if (32'(window_ff) > MAX_WINDOW) limit = COUNT_W'(MAX_WINDOW);
   end

   assign hi_word = raw_word[RAW_W-1 -: SAMPLE_W];
   assign mag_in  = hi_word[SAMPLE_W-1] ? (~hi_word + SAMPLE_W'(1)) : hi_word;

   assign square    = SQUARE_W'(mag_ff) * SQUARE_W'(mag_ff);
   assign sum_new   = sum_ff + SUM_W'(square);
   assign count_new = count_ff + COUNT_W'(1);
   assign close     = fail_ff || (count_new >= limit);

   assign div_trial = {rem_ff, work_ff[SUM_W-1]};
   assign div_ge    = div_trial >= {1'b0, div_ff};
   assign div_diff  = div_trial - {1'b0, div_ff};

   assign sq_shift  = {sqrem_ff, work_ff[SUM_W-1 -: 2]};
   assign sq_trial  = (SQREM_W+2)'({root_ff, 2'b01});
   assign sq_ge     = sq_shift >= sq_trial;
   assign sq_diff   = sq_shift - sq_trial;

   assign div_last  = iter_ff == ITER_W'(DIV_STEPS - 1);
   assign sqrt_last = iter_ff == ITER_W'(SQRT_STEPS - 1);

   assign level_prod   = LEVEL_PROD_W'(root_ff) * LEVEL_PROD_W'(LEVEL_SCALE);
   assign level_scaled = level_prod[LEVEL_PROD_W-1:FULL_SCALE_SHIFT];
   assign level_in     = (32'(level_scaled) > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX)
                                                         : LEVEL_W'(level_scaled);

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.close     = close;
   assign status.div_last  = div_last;
   assign status.sqrt_last = sqrt_last;
   assign status.out_free  = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rms_value    = rms_ff;
   assign level        = level_ff;
   assign sample_count = count_rsp_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) window_ff <= csr_wr_data;

         if (cmd.accum) begin
            if (close) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_new;
               count_ff <= count_new;
            end
            iter_ff <= '0;
         end else if (cmd.div_step) begin
            iter_ff <= div_last ? '0 : iter_ff + ITER_W'(1);
         end else if (cmd.sqrt_step) begin
            iter_ff <= sqrt_last ? '0 : iter_ff + ITER_W'(1);
         end

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff  <= mag_in;
         fail_ff <= read_failed;
      end

      if (cmd.accum && close) begin
         sqrem_ff <= '0;
         root_ff  <= '0;
         rem_ff   <= '0;
         if (fail_ff) begin
            // Empty window divides zero by one
            work_ff      <= (count_ff == '0) ? '0 : sum_ff;
            div_ff       <= (count_ff == '0) ? COUNT_W'(1) : count_ff;
            count_out_ff <= count_ff;
         end else begin
            work_ff      <= sum_new;
            div_ff       <= count_new;
            count_out_ff <= count_new;
         end
      end else if (cmd.div_step) begin
         rem_ff  <= div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
         work_ff <= {work_ff[SUM_W-2:0], div_ge};
      end else if (cmd.sqrt_step) begin
         sqrem_ff <= sq_ge ? sq_diff[SQREM_W-1:0] : sq_shift[SQREM_W-1:0];
         root_ff  <= {root_ff[ROOT_W-2:0], sq_ge};
         work_ff  <= {work_ff[SUM_W-3:0], 2'b00};
      end

      if (cmd.emit) begin
         rms_ff       <= root_ff[RMS_W-1:0];
         level_ff     <= level_in;
         count_rsp_ff <= count_out_ff;
      end
   end

endmodule

`default_nettype wire

@@ sv/rms_audio_level_meter.sv @@
// Top level: RMS audio level meter built from a controller and a datapath.
//
//   channel  | direction | transfer content
//   ---------+-----------+----------------------------------------------
//   req_bus  | in        | raw_word (32b signed), read_failed (1b)
//   rsp_bus  | out       | rms_value (16b), level (7b), sample_count (8b)
//   csr_*    | in        | window_length write, taken at any clock edge with csr_wr_en high
//
// An item that leaves the window open passes through capture and accumulate.
// An item that closes the window passes through capture, accumulate, 38 steps of
// the one-bit restoring divider, 19 steps of the two-bit square root, result load.
// The result load waits while the output register still holds an untaken result;
// the output register lets the next item enter while a result sits on rsp_bus.
// Reset is synchronous; window length returns to 100, the window empties.
`default_nettype none

module rms_audio_level_meter import rmslm_pkg::*; (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_wr_en,
   input  wire  [COUNT_W-1:0]   csr_wr_data,
   rmslm_req_if.sink            req_bus,
   rmslm_rsp_if.source          rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // Sequence each item: capture on transfer, then accumulate and, on close,
   // divide, take the root and load the result.
   rmslm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the window sums, run the shared iteration counter for divide and
   // square root, and drive the result register straight onto rsp_bus.
   rmslm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd          (cmd),
      .status       (status),
      .raw_word     (req_bus.raw_word),
      .read_failed  (req_bus.read_failed),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .rms_value    (rsp_bus.rms_value),
      .level        (rsp_bus.level),
      .sample_count (rsp_bus.sample_count)
   );

endmodule

`default_nettype wire

@@ sv/rmslm_checker.sv @@
// Checker: port-level assertions on the level meter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rmslm_checker import rmslm_pkg::*; (
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire [RMS_W-1:0]     rms_value,
   input wire [LEVEL_W-1:0]   level,
   input wire [COUNT_W-1:0]   sample_count
);

   logic [RMS_W+LEVEL_W-1:0]                  scaled_full;
   logic [RMS_W+LEVEL_W-FULL_SCALE_SHIFT-1:0] scaled;
   logic [LEVEL_W-1:0]                        exp_level;

   assign scaled_full = (RMS_W+LEVEL_W)'(rms_value) * (RMS_W+LEVEL_W)'(LEVEL_SCALE);
   assign scaled      = scaled_full[RMS_W+LEVEL_W-1:FULL_SCALE_SHIFT];
   assign exp_level   = (32'(scaled) > LEVEL_MAX) ? LEVEL_W'(LEVEL_MAX) : LEVEL_W'(scaled);

   `ASSERT_IMPLY(a_rsp_idle_after_reset, clock, 1'b0, $past(reset), !rsp_valid, "result valid right after reset")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rms_value) && $stable(level) && $stable(sample_count), "stalled result changed")

   `ASSERT_IMPLY(a_level_matches_rms, clock, reset, rsp_valid, level == exp_level, "level does not follow rms_value")

   `ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, (sample_count != '0 || rms_value == '0) && 32'(sample_count) <= MAX_WINDOW, "bad sample_count or nonzero rms for empty window")

endmodule

bind rms_audio_level_meter rmslm_checker u_rmslm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rms_value    (rsp_bus.rms_value),
   .level        (rsp_bus.level),
   .sample_count (rsp_bus.sample_count)
);

`default_nettype wire
